FILE: design/assert_macros.svh
// assertion helpers used by the record slot allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RSA_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define RSA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rsa_pkg.sv
`default_nettype none

package rsa_pkg;

  // fixed field widths of the request and response channels
  localparam int MODE_W = 2;
  localparam int PAGE_W = 9;
  localparam int SLOT_W = 6;
  localparam int RPP_W  = 7;

  // defaults for the top-level parameters
  localparam int MAX_PAGES_DEF = 256;
  localparam int MAX_SLOTS_DEF = 64;

  // records per page after reset
  localparam logic [RPP_W-1:0] RPP_RESET = 7'd64;

  // request modes; the remaining code is rejected as an invalid id
  typedef enum logic [MODE_W-1:0] {
    MD_INSERT = 2'd0,
    MD_DELETE = 2'd1,
    MD_CHECK  = 2'd2
  } mode_t;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ID   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NO_SPACE = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_PICK,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

FILE: design/rsa_req_if.sv
`default_nettype none

interface rsa_req_if;
  import rsa_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [PAGE_W-1:0] page_index;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, mode, page_index, slot_index, input ready);
  modport sink   (input valid, mode, page_index, slot_index, output ready);
endinterface

`default_nettype wire

FILE: design/rsa_rsp_if.sv
`default_nettype none

interface rsa_rsp_if;
  import rsa_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [PAGE_W-1:0] result_page;
  logic [SLOT_W-1:0] result_slot;

  modport source (output valid, status, result_page, result_slot, input ready);
  modport sink   (input valid, status, result_page, result_slot, output ready);
endinterface

`default_nettype wire

FILE: design/record_slot_allocator.sv
// Record slot allocator over fixed-size pages. Each opened page keeps a slot
// bitmap, a record count and a link in a list of pages with free slots, all
// in one page memory with a registered read; nothing is cleared after
// reset, since only pages that have been opened are ever read. An insert
// takes the lowest free slot of the list head page, opening page
// pages_in_use+1 when the list is empty, and answers no space once all pages
// are full. Delete and check validate the id first. A rejected request or an
// insert that opens a page goes straight to the result; delete and check
// read the page memory, then evaluate and write back; an insert into a listed
// page also runs the two-step free-slot search over the bitmap before the
// write back. A new request is taken in the cycle the previous response
// moves into the output register, which holds it until the sink takes it.
`default_nettype none

module record_slot_allocator #(
  parameter int MAX_PAGES = rsa_pkg::MAX_PAGES_DEF,
  parameter int MAX_SLOTS = rsa_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [rsa_pkg::RPP_W-1:0] cfg_wr_data,
  rsa_req_if.sink                        in_req,
  rsa_rsp_if.source                      out_rsp
);
  import rsa_pkg::*;

`include "assert_macros.svh"

  localparam int PCNT_W = $clog2(MAX_PAGES + 1);
  localparam int ADDR_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int SIDX_W = $clog2(MAX_SLOTS);
  localparam int NCNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W  = (PCNT_W > PAGE_W) ? PCNT_W : PAGE_W;
  localparam int ENT_W  = 1 + PCNT_W + NCNT_W + MAX_SLOTS;

  // control state
  state_t            state_r, state_nxt;
  logic [PCNT_W-1:0] head_r, head_nxt;
  logic [PCNT_W-1:0] pages_r, pages_nxt;
  logic [RPP_W-1:0]  rpp_r;
  logic              out_valid_r;

  // request and result holding registers
  logic [MODE_W-1:0] mode_r;
  logic [PAGE_W-1:0] req_pg_r;
  logic [SLOT_W-1:0] req_sl_r;
  logic [PCNT_W-1:0] pg_num_r;
  status_t           res_st_r, res_st_nxt;
  logic [PAGE_W-1:0] res_pg_r, res_pg_nxt;
  logic [SLOT_W-1:0] res_sl_r, res_sl_nxt;
  status_t           out_st_r;
  logic [PAGE_W-1:0] out_pg_r;
  logic [SLOT_W-1:0] out_sl_r;

  // handshake
  logic in_ready;
  logic in_acc;
  logic out_free;
  logic out_ld;

  // page memory ports
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [ENT_W-1:0]  mem_wr_data;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [ENT_W-1:0]  mem_rd_data;

  // slot search
  logic              fnd_ld;
  logic              fnd_found;
  logic [SIDX_W-1:0] fnd_slot;

  // derived values
  logic [RPP_W-1:0]     n_full;
  logic [NCNT_W-1:0]    n;
  logic [CMP_W-1:0]     in_pg_ext;
  logic [CMP_W-1:0]     pages_ext;
  logic                 id_ok;
  logic [PCNT_W-1:0]    acc_pg;
  logic [PCNT_W-1:0]    acc_pg_m1;
  logic [PCNT_W-1:0]    new_pg;
  logic [CMP_W-1:0]     new_pg_ext;
  logic [CMP_W-1:0]     num_pg_ext;
  logic [PCNT_W-1:0]    num_m1;
  logic [MAX_SLOTS-1:0] ent_bits;
  logic [NCNT_W-1:0]    ent_cnt;
  logic [PCNT_W-1:0]    ent_link;
  logic                 ent_inl;
  logic [SIDX_W-1:0]    sl_idx;
  logic                 bit_hit;
  logic [MAX_SLOTS-1:0] bits_clr;
  logic [MAX_SLOTS-1:0] bits_set;
  logic [NCNT_W-1:0]    cnt_dec;
  logic [NCNT_W-1:0]    cnt_inc;
  logic                 relink;
  logic                 full;

  // slots in use per page and id range
  assign n_full    = (rpp_r > RPP_W'(MAX_SLOTS)) ? RPP_W'(MAX_SLOTS) : rpp_r;
  assign n         = n_full[NCNT_W-1:0];
  assign in_pg_ext = CMP_W'(in_req.page_index);
  assign pages_ext = CMP_W'(pages_r);
  assign id_ok     = (in_pg_ext != '0) && (in_pg_ext <= pages_ext)
                     && ({1'b0, in_req.slot_index} < n_full);

  // page addressed by an accepted request
  assign acc_pg     = (in_req.mode == MD_INSERT) ? head_r : in_pg_ext[PCNT_W-1:0];
  assign acc_pg_m1  = acc_pg - PCNT_W'(1);
  assign new_pg     = pages_r + PCNT_W'(1);
  assign new_pg_ext = CMP_W'(new_pg);
  assign num_pg_ext = CMP_W'(pg_num_r);
  assign num_m1     = pg_num_r - PCNT_W'(1);

  // page entry fields
  assign ent_bits = mem_rd_data[MAX_SLOTS-1:0];
  assign ent_cnt  = mem_rd_data[MAX_SLOTS +: NCNT_W];
  assign ent_link = mem_rd_data[MAX_SLOTS + NCNT_W +: PCNT_W];
  assign ent_inl  = mem_rd_data[ENT_W-1];

  // delete and check on the addressed slot
  assign sl_idx   = req_sl_r[SIDX_W-1:0];
  assign bit_hit  = ent_bits[sl_idx];
  assign bits_clr = ent_bits & ~(MAX_SLOTS'(1) << sl_idx);
  assign cnt_dec  = (ent_cnt != '0) ? ent_cnt - NCNT_W'(1) : ent_cnt;
  assign relink   = !ent_inl && (cnt_dec < n);

  // insert into the found slot
  assign bits_set = ent_bits | (MAX_SLOTS'(1) << fnd_slot);
  assign cnt_inc  = ent_cnt + NCNT_W'(1);
  assign full     = cnt_inc >= n;

  assign out_free = !out_valid_r || out_rsp.ready;

  rsa_page_mem #(
    .DEPTH  (MAX_PAGES),
    .WIDTH  (ENT_W),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  rsa_slot_find #(
    .MAX_SLOTS (MAX_SLOTS),
    .SIDX_W    (SIDX_W),
    .NCNT_W    (NCNT_W)
  ) u_find (
    .clk   (clk),
    .ld    (fnd_ld),
    .bits  (ent_bits),
    .n     (n),
    .found (fnd_found),
    .slot  (fnd_slot)
  );

  // sequencer: read, evaluate, write back, hand over
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    pages_nxt   = pages_r;
    res_st_nxt  = res_st_r;
    res_pg_nxt  = res_pg_r;
    res_sl_nxt  = res_sl_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    fnd_ld      = 1'b0;
    in_ready    = 1'b0;
    out_ld      = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_EVAL: begin
        if (mode_r == MD_INSERT) begin
          fnd_ld    = 1'b1;
          state_nxt = S_PICK;
        end else begin
          res_pg_nxt = req_pg_r;
          res_sl_nxt = req_sl_r;
          state_nxt  = S_FIN;
          if (!bit_hit) begin
            res_st_nxt = ST_EMPTY;
          end else begin
            res_st_nxt = ST_OK;
            if (mode_r == MD_DELETE) begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = num_m1[ADDR_W-1:0];
              mem_wr_data = {ent_inl | relink, relink ? head_r : ent_link,
                             cnt_dec, bits_clr};
              if (relink) begin
                head_nxt = pg_num_r;
              end
            end
          end
        end
      end
      S_PICK: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = num_m1[ADDR_W-1:0];
        state_nxt   = S_FIN;
        if (!fnd_found) begin
          // head page has no slot left below the current limit
          head_nxt    = ent_link;
          mem_wr_data = {1'b0, ent_link, ent_cnt, ent_bits};
          res_st_nxt  = ST_NO_SPACE;
          res_pg_nxt  = '0;
          res_sl_nxt  = '0;
        end else begin
          mem_wr_data = {ent_inl & !full, ent_link, cnt_inc, bits_set};
          if (full) begin
            head_nxt = ent_link;
          end
          res_st_nxt = ST_OK;
          res_pg_nxt = num_pg_ext[PAGE_W-1:0];
          res_sl_nxt = SLOT_W'(fnd_slot);
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_ld    = 1'b1;
          in_ready  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // request decode at accept
    in_acc = in_req.valid && in_ready;
    if (in_acc) begin
      state_nxt  = S_FIN;
      res_pg_nxt = in_req.page_index;
      res_sl_nxt = in_req.slot_index;
      case (in_req.mode)
        MD_INSERT: begin
          res_pg_nxt = '0;
          res_sl_nxt = '0;
          if (n == '0) begin
            res_st_nxt = ST_NO_SPACE;
          end else if (head_r != '0) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = acc_pg_m1[ADDR_W-1:0];
            state_nxt   = S_EVAL;
          end else if (pages_r == PCNT_W'(MAX_PAGES)) begin
            res_st_nxt = ST_NO_SPACE;
          end else begin
            // open a fresh page and take its first slot
            mem_wr_en   = 1'b1;
            mem_wr_addr = pages_r[ADDR_W-1:0];
            mem_wr_data = {n > NCNT_W'(1), PCNT_W'(0), NCNT_W'(1), MAX_SLOTS'(1)};
            pages_nxt   = new_pg;
            head_nxt    = (n > NCNT_W'(1)) ? new_pg : '0;
            res_st_nxt  = ST_OK;
            res_pg_nxt  = new_pg_ext[PAGE_W-1:0];
          end
        end
        MD_DELETE, MD_CHECK: begin
          if (id_ok) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = acc_pg_m1[ADDR_W-1:0];
            state_nxt   = S_EVAL;
          end else begin
            res_st_nxt = ST_BAD_ID;
          end
        end
        default: begin
          res_st_nxt = ST_BAD_ID;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      pages_r     <= '0;
      rpp_r       <= RPP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      pages_r <= pages_nxt;
      if (cfg_wr_en) begin
        rpp_r <= cfg_wr_data;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and result registers
  always_ff @(posedge clk) begin
    res_st_r <= res_st_nxt;
    res_pg_r <= res_pg_nxt;
    res_sl_r <= res_sl_nxt;
    if (in_acc) begin
      mode_r   <= in_req.mode;
      req_pg_r <= in_req.page_index;
      req_sl_r <= in_req.slot_index;
      pg_num_r <= acc_pg;
    end
    if (out_ld) begin
      out_st_r <= res_st_r;
      out_pg_r <= res_pg_r;
      out_sl_r <= res_sl_r;
    end
  end

  assign in_req.ready        = in_ready;
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_st_r;
  assign out_rsp.result_page = out_pg_r;
  assign out_rsp.result_slot = out_sl_r;

  // list head is always an opened page or empty
  `RSA_ASSERT_IMPLY(a_head_range, clk, rst_n, 1'b1, head_r <= pages_r, "head beyond opened pages")
  // an accepted request always leaves idle
  `RSA_ASSERT_NEXT(a_acc_busy, clk, rst_n, in_acc, state_r != S_IDLE, "accept left sequencer idle")
  // a successful response always names a page other than zero
  `RSA_ASSERT_IMPLY(a_ok_page, clk, rst_n, out_valid_r && out_st_r == ST_OK, out_pg_r != '0, "ok with page zero")

endmodule

`default_nettype wire

FILE: design/rsa_page_mem.sv
`default_nettype none

module rsa_page_mem #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 81,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/rsa_slot_find.sv
`default_nettype none

module rsa_slot_find #(
  parameter int MAX_SLOTS = 64,
  parameter int SIDX_W    = 6,
  parameter int NCNT_W    = 7
) (
  input  wire logic                 clk,
  input  wire logic                 ld,
  input  wire logic [MAX_SLOTS-1:0] bits,
  input  wire logic [NCNT_W-1:0]    n,
  output logic                      found,
  output logic      [SIDX_W-1:0]    slot
);
  import rsa_pkg::*;

  localparam int GRPS = (MAX_SLOTS + 7) / 8;

  logic [GRPS*8-1:0] free_pad;
  logic [GRPS-1:0]   grp_any;
  logic [2:0]        grp_pos [GRPS];
  logic [GRPS-1:0]   grp_any_r;
  logic [2:0]        grp_pos_r [GRPS];

  // free slots below the slot limit, padded to whole bytes
  always_comb begin
    free_pad = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      free_pad[i] = !bits[i] && (NCNT_W'(i) < n);
    end
  end

  // first step: lowest free slot within each byte
  always_comb begin
    for (int g = 0; g < GRPS; g++) begin
      grp_any[g] = |free_pad[g*8 +: 8];
      grp_pos[g] = 3'd0;
      for (int j = 7; j >= 0; j--) begin
        if (free_pad[g*8 + j]) begin
          grp_pos[g] = 3'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      grp_any_r <= grp_any;
      for (int g = 0; g < GRPS; g++) begin
        grp_pos_r[g] <= grp_pos[g];
      end
    end
  end

  // second step: lowest byte that has a free slot
  always_comb begin
    found = |grp_any_r;
    slot  = '0;
    for (int g = GRPS - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        slot = SIDX_W'(g * 8 + int'(grp_pos_r[g]));
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_record_slot_allocator.sv
`timescale 1ns / 100ps

module tb_record_slot_allocator;
  import rsa_pkg::*;

  localparam int PAGE_LIMIT = MAX_PAGES_DEF;
  localparam int SLOT_LIMIT = MAX_SLOTS_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // one response as the allocator should give it
  typedef struct packed {
    status_t           status;
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] slot;
  } slot_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [RPP_W-1:0] cfg_wr_data;

  rsa_req_if req_if();
  rsa_rsp_if rsp_if();

  record_slot_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_req     (req_if),
    .out_rsp    (rsp_if)
  );

  // shadow copy of the page store and free list
  logic [SLOT_LIMIT-1:0] page_bits [0:PAGE_LIMIT];
  logic [RPP_W-1:0]      page_count [0:PAGE_LIMIT];
  logic [PAGE_W-1:0]     page_link [0:PAGE_LIMIT];
  bit                    page_listed [0:PAGE_LIMIT];
  int unsigned           free_head;
  int unsigned           pages_used;
  int unsigned           records_per_page;

  slot_result_t expected_results [$];
  slot_result_t oldest_result;
  int unsigned  mismatch_count;
  bit           sender_gaps;
  bit           receiver_stalls;

  // clock
  always #10 clk = ~clk;

  // run limit
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned slots_in_use();
    return (records_per_page > SLOT_LIMIT) ? SLOT_LIMIT : records_per_page;
  endfunction

  // work out the response to one accepted request and update the shadow state
  function automatic slot_result_t apply_request(logic [MODE_W-1:0] m, logic [PAGE_W-1:0] pg,
                                                 logic [SLOT_W-1:0] sl);
    slot_result_t res;
    int unsigned  n;
    int unsigned  hp;
    int unsigned  s;
    n = slots_in_use();
    res = '{ST_BAD_ID, pg, sl};
    if (m == MD_INSERT) begin
      res = '{ST_NO_SPACE, '0, '0};
      if (n == 0) return res;
      // empty list: open the next page
      if (free_head == 0) begin
        if (pages_used >= PAGE_LIMIT) return res;
        pages_used++;
        hp = pages_used;
        page_bits[hp] = '0;
        page_count[hp] = '0;
        page_link[hp] = '0;
        page_listed[hp] = 1'b1;
        free_head = hp;
      end
      hp = free_head;
      for (s = 0; s < n; s++)
        if (!page_bits[hp][s]) break;
      // head page has no room under the current setting
      if (s >= n) begin
        free_head = page_link[hp];
        page_listed[hp] = 1'b0;
        return res;
      end
      page_bits[hp][s] = 1'b1;
      if (page_count[hp] < 7'd127) page_count[hp]++;
      if (page_count[hp] >= n) begin
        free_head = page_link[hp];
        page_listed[hp] = 1'b0;
      end
      res = '{ST_OK, hp[PAGE_W-1:0], s[SLOT_W-1:0]};
      return res;
    end
    if (m == MODE_UNUSED || pg == 0 || pg > pages_used || sl >= n) return res;
    if (!page_bits[pg][sl]) begin
      res.status = ST_EMPTY;
      return res;
    end
    if (m == MD_DELETE) begin
      page_bits[pg][sl] = 1'b0;
      if (page_count[pg] > 0) page_count[pg]--;
      // page regains room: back to the head of the list
      if (!page_listed[pg] && page_count[pg] < n) begin
        page_link[pg] = PAGE_W'(free_head);
        free_head = pg;
        page_listed[pg] = 1'b1;
      end
    end
    res.status = ST_OK;
    return res;
  endfunction

  // random id that currently holds a record, when one is found quickly
  function automatic bit pick_occupied(output logic [PAGE_W-1:0] pg,
                                       output logic [SLOT_W-1:0] sl);
    int unsigned n;
    n = slots_in_use();
    pg = '0;
    sl = '0;
    if (pages_used == 0 || n == 0) return 1'b0;
    repeat (24) begin
      pg = PAGE_W'($urandom_range(1, pages_used));
      sl = SLOT_W'($urandom_range(0, n - 1));
      if (page_bits[pg][sl]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // send one request, optionally after a short gap
  task automatic send_request(logic [MODE_W-1:0] m, logic [PAGE_W-1:0] pg,
                              logic [SLOT_W-1:0] sl);
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= m;
    req_if.page_index <= pg;
    req_if.slot_index <= sl;
    do @(posedge clk); while (!req_if.ready);
    expected_results.push_back(apply_request(m, pg, sl));
  endtask

  // stop sending and wait for every outstanding response
  task automatic drain_responses();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // register write, only with the allocator idle
  task automatic write_records_per_page(logic [RPP_W-1:0] value);
    drain_responses();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    records_per_page = value;
  endtask

  // mostly inserts and deletes of live records, some checks and some noise
  task automatic send_random_request();
    int unsigned       pick;
    logic [PAGE_W-1:0] pg;
    logic [SLOT_W-1:0] sl;
    pick = $urandom_range(0, 99);
    pg = PAGE_W'($urandom_range(0, 511));
    sl = SLOT_W'($urandom_range(0, 63));
    if (pick < 45) begin
      send_request(MD_INSERT, pg, sl);
    end else if (pick < 75) begin
      void'(pick_occupied(pg, sl));
      send_request(MD_DELETE, pg, sl);
    end else if (pick < 90) begin
      if ($urandom_range(0, 1) == 1) void'(pick_occupied(pg, sl));
      else if (pages_used > 0) pg = PAGE_W'($urandom_range(1, pages_used));
      send_request(MD_CHECK, pg, sl);
    end else begin
      send_request(MODE_W'($urandom_range(0, 3)), pg, sl);
    end
  endtask

  task automatic run_random_requests(int unsigned count, logic [RPP_W-1:0] rpp,
                                     bit hold_midway);
    int unsigned i;
    write_records_per_page(rpp);
    for (i = 0; i < count; i++) begin
      if (hold_midway && i == count / 2) drain_responses();
      send_random_request();
    end
  endtask

  // reset setting: first page, reuse of a freed slot, id checks
  task automatic test_basic_requests();
    send_request(MD_CHECK, 9'd0, 6'd0);
    repeat (3) send_request(MD_INSERT, 9'd0, 6'd0);
    send_request(MD_CHECK, 9'd1, 6'd0);
    send_request(MD_CHECK, 9'd1, 6'd63);
    send_request(MD_DELETE, 9'd1, 6'd1);
    send_request(MD_DELETE, 9'd1, 6'd1);
    send_request(MD_INSERT, 9'h1ff, 6'h3f);
    send_request(MD_CHECK, 9'd2, 6'd0);
    send_request(MODE_UNUSED, 9'd1, 6'd0);
    send_request(MD_DELETE, 9'h1ff, 6'h3f);
    send_request(MD_CHECK, 9'd256, 6'd0);
  endtask

  // head page over the new limit, then relink once it has room again
  task automatic test_shrunk_head_page();
    write_records_per_page(7'd2);
    repeat (3) send_request(MD_INSERT, 9'd0, 6'd0);
    send_request(MD_CHECK, 9'd1, 6'd2);
    send_request(MD_DELETE, 9'd1, 6'd0);
    send_request(MD_DELETE, 9'd1, 6'd1);
    send_request(MD_INSERT, 9'd0, 6'd0);
  endtask

  // zero slots per page: no space, every id rejected
  task automatic test_zero_records();
    write_records_per_page(7'd0);
    send_request(MD_INSERT, 9'd0, 6'd0);
    send_request(MD_CHECK, 9'd1, 6'd0);
  endtask

  // one slot per page until every page is open and full
  task automatic test_exhaust_pages();
    int unsigned guard;
    write_records_per_page(7'd1);
    guard = 0;
    while (pages_used < PAGE_LIMIT && guard < 600) begin
      send_request(MD_INSERT, PAGE_W'($urandom_range(0, 511)),
                   SLOT_W'($urandom_range(0, 63)));
      guard++;
    end
    repeat (3) send_request(MD_INSERT, 9'd0, 6'd0);
    send_request(MD_CHECK, 9'd256, 6'd0);
    send_request(MD_DELETE, 9'd256, 6'd0);
    send_request(MD_CHECK, 9'd256, 6'd0);
    send_request(MD_INSERT, 9'd0, 6'd0);
    send_request(MD_INSERT, 9'd0, 6'd0);
  endtask

  task automatic test_random_partial_pages();
    run_random_requests(250, 7'd64, 1'b1);
  endtask

  task automatic test_random_small_pages();
    run_random_requests(150, 7'd3, 1'b0);
  endtask

  task automatic test_random_all_pages_open();
    run_random_requests(200, 7'd64, 1'b1);
  endtask

  task automatic test_random_wide_setting();
    run_random_requests(150, 7'd127, 1'b0);
  endtask

  task automatic test_random_back_to_back();
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    run_random_requests(150, 7'd37, 1'b0);
  endtask

  // response side: random stall bursts
  always begin
    @(negedge clk);
    if (receiver_stalls && $urandom_range(0, 4) == 0) begin
      rsp_if.ready <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    rsp_if.ready <= 1'b1;
  end

  // compare each response with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected response: status=%0d page=%0d slot=%0d",
                   rsp_if.status, rsp_if.result_page, rsp_if.result_slot);
      end else begin
        oldest_result = expected_results.pop_front();
        if (rsp_if.status !== oldest_result.status ||
            rsp_if.result_page !== oldest_result.page ||
            rsp_if.result_slot !== oldest_result.slot) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status=%0d page=%0d slot=%0d, got %0d %0d %0d",
                     oldest_result.status, oldest_result.page, oldest_result.slot,
                     rsp_if.status, rsp_if.result_page, rsp_if.result_slot);
        end
      end
    end
  end

  // reset, then the tests in turn
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_if.valid = 1'b0;
    req_if.mode = '0;
    req_if.page_index = '0;
    req_if.slot_index = '0;
    rsp_if.ready = 1'b0;
    mismatch_count = 0;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    free_head = 0;
    pages_used = 0;
    records_per_page = RPP_RESET;
    for (int p = 0; p <= PAGE_LIMIT; p++) begin
      page_bits[p] = '0;
      page_count[p] = '0;
      page_link[p] = '0;
      page_listed[p] = 1'b0;
    end
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_basic_requests();
    test_shrunk_head_page();
    test_zero_records();
    test_random_partial_pages();
    test_random_small_pages();
    test_exhaust_pages();
    test_random_all_pages_open();
    test_random_wide_setting();
    test_random_back_to_back();

    drain_responses();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
